>>> hw/rtl/byo_pkg.sv
`default_nettype none

package byo_pkg;

	localparam int MARGIN_CS_DEF = 200;
	localparam int ONE_MONTH_CS  = 31 * 24 * 60 * 60 * 100;

	localparam int MAIN_W   = 24;
	localparam int LEN_W    = 19;
	localparam int CNT_W    = 8;
	localparam int BOARD_W  = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_MAIN_TIME  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OT_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OT_STONES  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OT_PERIODS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BOARD_SIZE = 3'd4;

	localparam logic [MAIN_W-1:0]  MAIN_TIME_RST  = '0;
	localparam logic [LEN_W-1:0]   OT_LENGTH_RST  = '0;
	localparam logic [CNT_W-1:0]   OT_STONES_RST  = '0;
	localparam logic [CNT_W-1:0]   OT_PERIODS_RST = '0;
	localparam logic [BOARD_W-1:0] BOARD_SIZE_RST = 5'd19;

	localparam logic [1:0] REQ_MOVE   = 2'd0;
	localparam logic [1:0] REQ_SET    = 2'd1;
	localparam logic [1:0] REQ_RELOAD = 2'd2;

	// expected moves: size squared over six, never below one
	localparam logic [7:0] MOVES_TAB [32] = '{
		8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd4,   8'd6,   8'd8,
		8'd10,  8'd13,  8'd16,  8'd20,  8'd24,  8'd28,  8'd32,  8'd37,
		8'd42,  8'd48,  8'd54,  8'd60,  8'd66,  8'd73,  8'd80,  8'd88,
		8'd96,  8'd104, 8'd112, 8'd121, 8'd130, 8'd140, 8'd150, 8'd160
	};

endpackage

`default_nettype wire

>>> hw/rtl/byoyomi_clock_and_move_budget_top.sv
// Two-player byo-yomi game clock with a move budget, in centiseconds.
// Request channel (req_valid / req_stall): req_type, player, elapsed_time,
// set_time, set_count. One request is taken at a time; req_stall stays high
// from acceptance until the result has been loaded into the output register.
// Response channel (rsp_valid / rsp_stall): one result per request, held in
// an output register while rsp_stall is high; a new request may be taken
// while it waits.
// In main time a Canadian block must first be split per stone; the one-month
// budget needs no division. A result may wait for an earlier one to leave;
// the next request is taken the cycle after it has been loaded. The budget
// comes from a shared restoring divider, one quotient bit a cycle over a
// 34-bit dividend, used twice for a Canadian block in main time, not at all
// for the one-month budget, else once. Configuration (cfg_we / cfg_idx /
// cfg_data) must be written while idle; the block does not enforce this.
// Main time only reaches the clocks on a reload request or at reset.
// Reset: configuration registers return to their reset values, both clocks
// load from them, no response is pending.
`default_nettype none

module byoyomi_clock_and_move_budget_top #(
	parameter int MARGIN_CS = byo_pkg::MARGIN_CS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,

	input  wire                                    cfg_we,
	input  wire [byo_pkg::CFG_IDX_W-1:0]           cfg_idx,
	input  wire [byo_pkg::CFG_DATA_W-1:0]          cfg_data,

	input  wire                                    req_valid,
	output logic                                   req_stall,
	input  wire [1:0]                              req_type,
	input  wire                                    player,
	input  wire [23:0]                             elapsed_time,
	input  wire [23:0]                             set_time,
	input  wire [7:0]                              set_count,

	output logic                                   rsp_valid,
	input  wire                                    rsp_stall,
	output logic signed [31:0]                     time_left,
	output logic signed [8:0]                      stones_remaining,
	output logic signed [8:0]                      periods_remaining,
	output logic                                   in_overtime,
	output logic signed [31:0]                     move_budget
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_NUM  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam int DIV_W = 34;
	localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);
	localparam logic signed [35:0] MARGIN_W = 36'(MARGIN_CS);
	localparam logic signed [31:0] MONTH_W = 32'(byo_pkg::ONE_MONTH_CS);

	logic [2:0] state_q;

	logic [byo_pkg::MAIN_W-1:0]  main_time_q;
	logic [byo_pkg::LEN_W-1:0]   ot_len_q;
	logic [byo_pkg::CNT_W-1:0]   ot_stones_q;
	logic [byo_pkg::CNT_W-1:0]   ot_periods_q;
	logic [byo_pkg::BOARD_W-1:0] board_size_q;

	logic signed [31:0] rt_q [2];
	logic signed [8:0]  sl_q [2];
	logic signed [8:0]  pl_q [2];
	logic               of_q [2];

	logic [1:0]  req_type_q;
	logic        player_q;
	logic [23:0] elapsed_q;
	logic [23:0] set_time_q;
	logic [7:0]  set_count_q;

	logic signed [29:0] prod_q;
	logic [18:0]        extra_q;
	logic signed [35:0] add_q;
	logic               neg_q;
	logic               month_q;
	logic               phase1_q;
	logic [DIV_W-1:0]   dn_q;
	logic [7:0]         dr_q;
	logic [7:0]         dd_q;
	logic [5:0]         cnt_q;

	logic signed [31:0] cur_rt;
	logic signed [8:0]  cur_sl;
	logic signed [8:0]  cur_pl;
	logic               cur_of;

	logic signed [31:0] nx_rt;
	logic signed [8:0]  nx_sl;
	logic signed [8:0]  nx_pl;
	logic               nx_of;
	logic signed [32:0] sub;
	logic signed [31:0] sub_sat;
	logic signed [8:0]  sl_dec;
	logic signed [8:0]  pl_dec;

	logic signed [9:0]  pm1;
	logic signed [29:0] prod;
	logic [7:0]         moves;

	logic signed [35:0] num;
	logic signed [35:0] num_abs;
	logic [7:0]         dvs;
	logic signed [35:0] addend;
	logic               month;

	logic [8:0]         rsh;
	logic               ge;
	logic [7:0]         rnext;

	logic signed [35:0] qs;
	logic signed [35:0] a;
	logic signed [31:0] a_clamp;
	logic               out_free;

	assign cur_rt = rt_q[player_q];
	assign cur_sl = sl_q[player_q];
	assign cur_pl = pl_q[player_q];
	assign cur_of = of_q[player_q];
	assign moves  = byo_pkg::MOVES_TAB[board_size_q];

	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid || !rsp_stall;

	always_comb begin
		sub     = 33'(cur_rt) - $signed({9'd0, elapsed_q});
		sub_sat = (sub[32] != sub[31]) ? 32'sh8000_0000 : sub[31:0];
		sl_dec  = (cur_sl > -9'sd255) ? cur_sl - 9'sd1 : -9'sd255;
		pl_dec  = (cur_pl > -9'sd255) ? cur_pl - 9'sd1 : -9'sd255;
		nx_rt = cur_rt;
		nx_sl = cur_sl;
		nx_pl = cur_pl;
		nx_of = cur_of;
		unique case (req_type_q)
			byo_pkg::REQ_MOVE: begin
				nx_rt = sub_sat;
				if (cur_of) begin
					if (ot_stones_q != '0)
						nx_sl = sl_dec;
					else if (ot_periods_q != '0 && elapsed_q > {5'd0, ot_len_q})
						nx_pl = pl_dec;
				end
				if (!cur_of && sub_sat <= 32'sd0) begin
					nx_rt = 32'({13'd0, ot_len_q});
					nx_sl = 9'({1'b0, ot_stones_q});
					nx_pl = 9'({1'b0, ot_periods_q});
					nx_of = 1'b1;
				end else if (cur_of && ot_stones_q != '0 && sl_dec <= 9'sd0) begin
					nx_rt = 32'({13'd0, ot_len_q});
					nx_sl = 9'({1'b0, ot_stones_q});
				end else if (cur_of && ot_periods_q != '0) begin
					nx_rt = 32'({13'd0, ot_len_q});
				end
			end
			byo_pkg::REQ_SET: begin
				nx_rt = 32'({8'd0, set_time_q});
				if (set_count_q != '0)
					nx_of = 1'b1;
				if (ot_stones_q != '0)
					nx_sl = 9'({1'b0, set_count_q});
				else
					nx_pl = 9'({1'b0, set_count_q});
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		pm1  = 10'(cur_pl) - 10'sd1;
		prod = $signed({1'b0, ot_len_q}) * pm1;
	end

	always_comb begin
		logic signed [35:0] rem36;
		logic signed [35:0] len36;
		rem36  = 36'(cur_rt);
		len36  = 36'($signed({1'b0, ot_len_q}));
		month  = 1'b0;
		num    = rem36 - MARGIN_W;
		dvs    = moves;
		addend = '0;
		if (ot_len_q == '0) begin
			num = rem36 - MARGIN_W;
		end else if (ot_stones_q == '0 && ot_periods_q == '0) begin
			month = 1'b1;
		end else if (cur_of) begin
			if (ot_stones_q != '0) begin
				dvs = ot_stones_q;
			end else begin
				num    = 36'(prod_q) - MARGIN_W;
				addend = len36 - MARGIN_W;
			end
		end else begin
			if (ot_stones_q != '0) begin
				num    = rem36 + $signed({17'd0, extra_q}) - MARGIN_W;
				addend = $signed({17'd0, extra_q}) - MARGIN_W;
			end else begin
				num    = rem36 + 36'(prod_q) - MARGIN_W;
				addend = len36 - MARGIN_W;
			end
		end
		num_abs = num[35] ? -num : num;
	end

	// restoring divider step, one quotient bit per cycle
	always_comb begin
		rsh   = {dr_q, dn_q[DIV_W-1]};
		ge    = rsh >= {1'b0, dd_q};
		rnext = ge ? 8'(rsh - {1'b0, dd_q}) : rsh[7:0];
	end

	always_comb begin
		qs = 36'($signed({2'b0, dn_q}));
		if (neg_q)
			qs = -qs;
		a = qs + add_q;
		if (a < 36'sd0)
			a = '0;
		if (a > 36'(cur_rt))
			a = 36'(cur_rt);
		a_clamp = month_q ? MONTH_W : a[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_time_q  <= byo_pkg::MAIN_TIME_RST;
			ot_len_q     <= byo_pkg::OT_LENGTH_RST;
			ot_stones_q  <= byo_pkg::OT_STONES_RST;
			ot_periods_q <= byo_pkg::OT_PERIODS_RST;
			board_size_q <= byo_pkg::BOARD_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				byo_pkg::CFG_MAIN_TIME:  main_time_q  <= cfg_data[byo_pkg::MAIN_W-1:0];
				byo_pkg::CFG_OT_LENGTH:  ot_len_q     <= cfg_data[byo_pkg::LEN_W-1:0];
				byo_pkg::CFG_OT_STONES:  ot_stones_q  <= cfg_data[byo_pkg::CNT_W-1:0];
				byo_pkg::CFG_OT_PERIODS: ot_periods_q <= cfg_data[byo_pkg::CNT_W-1:0];
				byo_pkg::CFG_BOARD_SIZE: board_size_q <= cfg_data[byo_pkg::BOARD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				rt_q[i] <= 32'({8'd0, byo_pkg::MAIN_TIME_RST});
				sl_q[i] <= 9'({1'b0, byo_pkg::OT_STONES_RST});
				pl_q[i] <= 9'({1'b0, byo_pkg::OT_PERIODS_RST});
				of_q[i] <= (byo_pkg::MAIN_TIME_RST == '0);
			end
		end else if (state_q == ST_UPD) begin
			if (req_type_q == byo_pkg::REQ_RELOAD) begin
				for (int i = 0; i < 2; i++) begin
					rt_q[i] <= 32'({8'd0, main_time_q});
					sl_q[i] <= 9'({1'b0, ot_stones_q});
					pl_q[i] <= 9'({1'b0, ot_periods_q});
					of_q[i] <= (main_time_q == '0);
				end
			end else begin
				rt_q[player_q] <= nx_rt;
				sl_q[player_q] <= nx_sl;
				pl_q[player_q] <= nx_pl;
				of_q[player_q] <= nx_of;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rsp_valid <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free)
				rsp_valid <= 1'b1;
			else if (!rsp_stall)
				rsp_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid)
						state_q <= ST_UPD;
				end
				ST_UPD: state_q <= ST_PREP;
				ST_PREP: begin
					if (ot_len_q != '0 && ot_stones_q != '0 && !cur_of)
						state_q <= ST_DIV;
					else
						state_q <= ST_NUM;
				end
				ST_NUM: state_q <= month ? ST_FIN : ST_DIV;
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= phase1_q ? ST_NUM : ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				req_type_q  <= req_type;
				player_q    <= player;
				elapsed_q   <= elapsed_time;
				set_time_q  <= set_time;
				set_count_q <= set_count;
			end
			ST_PREP: begin
				prod_q   <= prod;
				extra_q  <= '0;
				neg_q    <= 1'b0;
				phase1_q <= 1'b1;
				dn_q     <= DIV_W'(ot_len_q);
				dr_q     <= '0;
				dd_q     <= ot_stones_q;
				cnt_q    <= DIV_LAST;
			end
			ST_NUM: begin
				month_q  <= month;
				phase1_q <= 1'b0;
				neg_q    <= num[35];
				add_q    <= addend;
				dn_q     <= num_abs[DIV_W-1:0];
				dr_q     <= '0;
				dd_q     <= dvs;
				cnt_q    <= DIV_LAST;
			end
			ST_DIV: begin
				dn_q  <= {dn_q[DIV_W-2:0], ge};
				dr_q  <= rnext;
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0 && phase1_q)
					extra_q <= {dn_q[17:0], ge};
			end
			ST_FIN: begin
				if (out_free) begin
					time_left         <= cur_rt;
					stones_remaining  <= cur_sl;
					periods_remaining <= cur_pl;
					in_overtime       <= cur_of;
					move_budget       <= a_clamp;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
